@@ rtl/ssw_pkg.sv @@
package ssw_pkg;

  localparam int unsigned POINT_CAPACITY_DEF = 64;

  // Fixed field widths
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned SIG_W    = 24;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned POINT_W  = 16;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned PROD_W   = SIG_W + GAIN_W + 1;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_PERIOD = 3'd0,
    REG_WINDOW_LENGTH = 3'd1,
    REG_SIGNAL_GAIN   = 3'd2,
    REG_SIGNAL_OFFSET = 3'd3,
    REG_QUAL_READY    = 3'd4,
    REG_QUAL_NREADY   = 3'd5
  } cfg_reg_e;

  // Reset values of the registers
  localparam logic [PERIOD_W-1:0]   SAMPLE_PERIOD_RST = 16'd200;
  localparam logic [TIME_W-1:0]     WINDOW_LENGTH_RST = 32'd10000;
  localparam logic [GAIN_W-1:0]     SIGNAL_GAIN_RST   = 16'd5000;
  localparam logic [GAIN_W-1:0]     SIGNAL_OFFSET_RST = 16'd32768;
  localparam logic [BYTE_W-1:0]     QUAL_READY_RST    = 8'd88;
  localparam logic [BYTE_W-1:0]     QUAL_NREADY_RST   = 8'd30;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_BEGIN = 1'b1;

endpackage

@@ rtl/ssw_if.sv @@
interface ssw_in_if;
  import ssw_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [TIME_W-1:0]        now_ms;
  logic                     enabled;
  logic [TIME_W-1:0]        session_id;
  logic signed [SIG_W-1:0]  signal;
  logic [BYTE_W-1:0]        resp_rate;
  logic                     sensor_ready;
  logic [BYTE_W-1:0]        motion_level;

  modport source (output valid, kind, now_ms, enabled, session_id, signal, resp_rate,
                  sensor_ready, motion_level, input ready);
  modport sink   (input valid, kind, now_ms, enabled, session_id, signal, resp_rate,
                  sensor_ready, motion_level, output ready);
endinterface

interface ssw_out_if;
  import ssw_pkg::*;

  logic                valid;
  logic                ready;
  logic [TIME_W-1:0]   session_out;
  logic [TIME_W-1:0]   window_number;
  logic [TIME_W-1:0]   window_start_ms;
  logic [TIME_W-1:0]   window_end_ms;
  logic [BYTE_W-1:0]   rate_out;
  logic [BYTE_W-1:0]   quality_out;
  logic [BYTE_W-1:0]   motion_out;
  logic [CNT_W-1:0]    points_in_window;
  logic                point_valid;
  logic [POINT_W-1:0]  point_value;
  logic                last_of_window;

  modport source (output valid, session_out, window_number, window_start_ms, window_end_ms,
                  rate_out, quality_out, motion_out, points_in_window, point_valid,
                  point_value, last_of_window, input ready);
  modport sink   (input valid, session_out, window_number, window_start_ms, window_end_ms,
                  rate_out, quality_out, motion_out, points_in_window, point_valid,
                  point_value, last_of_window, output ready);
endinterface

interface ssw_cfg_if;
  import ssw_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [CFG_DATA_W-1:0]  wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

@@ rtl/ssw_ram.sv @@
module ssw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/sensor_sample_windower.sv @@
// Tick items: accept, scale, then the sample-time remainder (bit-serial divider), then
// the window test. A closing window then emits each stored point by a memory read and
// a load, an empty window by a load alone; a busy output register stalls each load.
// Begin and disabled ticks are done once they are accepted.
// Reset (async, active low) restores register defaults, clears window number,
// start time and point count; the point memory is not cleared.
module sensor_sample_windower #(
  parameter int unsigned POINT_CAPACITY = ssw_pkg::POINT_CAPACITY_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  ssw_cfg_if.sink   cfg_i,
  ssw_in_if.sink    in_i,
  ssw_out_if.source res_o
);
  import ssw_pkg::*;

  localparam int unsigned AW = (POINT_CAPACITY > 1) ? $clog2(POINT_CAPACITY) : 1;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(POINT_CAPACITY);

  // Sequencer: one-hot
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CALC = 6'b000010,  // register product, decide whether a point may be stored
    S_DIV  = 6'b000100,  // now_ms mod sample period, one bit per cycle
    S_CHK  = 6'b001000,  // window length test, header snapshot
    S_RD   = 6'b010000,  // issue point memory read
    S_LD   = 6'b100000   // load result into the output register
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [PERIOD_W-1:0] period_q;
  logic [TIME_W-1:0]   length_q;
  logic [GAIN_W-1:0]   gain_q;
  logic [GAIN_W-1:0]   offset_q;
  logic [BYTE_W-1:0]   qual_rdy_q;
  logic [BYTE_W-1:0]   qual_nrdy_q;

  // Captured tick transaction
  logic [TIME_W-1:0]       now_q;
  logic [TIME_W-1:0]       sess_q;
  logic signed [SIG_W-1:0] sig_q;
  logic [BYTE_W-1:0]       rate_q;
  logic                    srdy_q;
  logic [BYTE_W-1:0]       motion_q;

  // Window state
  logic [TIME_W-1:0] wc_q;
  logic [TIME_W-1:0] start_q;
  logic [CNT_W-1:0]  cnt_q;

  // Datapath
  logic signed [PROD_W-1:0] prod_q;
  logic [TIME_W-1:0]        dvd_q;
  logic [PERIOD_W-1:0]      rem_q;
  logic [4:0]               it_q;

  // Header of the closing window and emit index
  logic [TIME_W-1:0] hdr_wc_q;
  logic [TIME_W-1:0] hdr_start_q;
  logic [CNT_W-1:0]  hdr_n_q;
  logic [CNT_W-1:0]  k_q;

  // Output register
  logic                ov_q;
  logic [TIME_W-1:0]   o_sess_q, o_wc_q, o_start_q, o_end_q;
  logic [BYTE_W-1:0]   o_rate_q, o_qual_q, o_motion_q;
  logic [CNT_W-1:0]    o_n_q;
  logic                o_pv_q, o_last_q;
  logic [POINT_W-1:0]  o_val_q;

  logic in_fire, tick_go, out_fire, ld_ok, ld_last, close_win;
  logic [PERIOD_W:0]  trial, trial_sub;
  logic               trial_ge;
  logic [PERIOD_W-1:0] rem_new;
  logic signed [PROD_W:0] scaled;
  logic [POINT_W-1:0]  point;
  logic                ram_we, ram_re;
  logic [POINT_W-1:0]  ram_rdata;
  logic [TIME_W-1:0]   elapsed;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == S_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign tick_go     = in_fire && (in_i.kind == KIND_TICK) && in_i.enabled;
  assign out_fire    = ov_q && res_o.ready;
  assign ld_ok       = !ov_q || res_o.ready;
  assign ld_last     = (hdr_n_q == '0) || (k_q == hdr_n_q - CNT_W'(1));

  // Restoring division step; the remainder always stays below the period.
  assign trial     = {rem_q, dvd_q[TIME_W-1]};
  assign trial_sub = trial - {1'b0, period_q};
  assign trial_ge  = (trial >= {1'b0, period_q});
  assign rem_new   = trial_ge ? trial_sub[PERIOD_W-1:0] : trial[PERIOD_W-1:0];

  // signal * gain + offset * 2^16, floored to integer, clamped to 0..65535
  assign scaled = {prod_q[PROD_W-1], prod_q} + $signed({10'd0, offset_q, 16'd0});
  always_comb begin
    if (scaled[PROD_W]) begin
      point = '0;
    end else if (|scaled[PROD_W-1:32]) begin
      point = '1;
    end else begin
      point = scaled[31:16];
    end
  end

  // Point stored on the last divider step when the remainder comes out zero
  assign ram_we    = (state_q == S_DIV) && (it_q == 5'd31) && (rem_new == '0);
  assign ram_re    = (state_q == S_RD);
  assign elapsed   = now_q - start_q;
  assign close_win = (elapsed >= length_q);

  ssw_ram #(
    .WIDTH (POINT_W),
    .DEPTH (POINT_CAPACITY)
  ) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (point),
    .re_i    (ram_re),
    .raddr_i (k_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (tick_go) begin
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        state_d = ((cnt_q < CAP) && (period_q != '0)) ? S_DIV : S_CHK;
      end
      S_DIV: begin
        if (it_q == 5'd31) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (close_win) begin
          state_d = (cnt_q != '0) ? S_RD : S_LD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RD: begin
        state_d = S_LD;
      end
      S_LD: begin
        if (ld_ok) begin
          state_d = ld_last ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      period_q    <= SAMPLE_PERIOD_RST;
      length_q    <= WINDOW_LENGTH_RST;
      gain_q      <= SIGNAL_GAIN_RST;
      offset_q    <= SIGNAL_OFFSET_RST;
      qual_rdy_q  <= QUAL_READY_RST;
      qual_nrdy_q <= QUAL_NREADY_RST;
      wc_q        <= '0;
      start_q     <= '0;
      cnt_q       <= '0;
      ov_q        <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_SAMPLE_PERIOD: period_q    <= cfg_i.wdata[PERIOD_W-1:0];
          REG_WINDOW_LENGTH: length_q    <= cfg_i.wdata[TIME_W-1:0];
          REG_SIGNAL_GAIN:   gain_q      <= cfg_i.wdata[GAIN_W-1:0];
          REG_SIGNAL_OFFSET: offset_q    <= cfg_i.wdata[GAIN_W-1:0];
          REG_QUAL_READY:    qual_rdy_q  <= cfg_i.wdata[BYTE_W-1:0];
          REG_QUAL_NREADY:   qual_nrdy_q <= cfg_i.wdata[BYTE_W-1:0];
          default: ;
        endcase
      end

      if (in_fire) begin
        if (in_i.kind == KIND_BEGIN) begin
          wc_q    <= '0;
          start_q <= in_i.now_ms;
          cnt_q   <= '0;
        end else if (!in_i.enabled) begin
          start_q <= in_i.now_ms;
          cnt_q   <= '0;
        end else if (wc_q == '0) begin
          // first enabled tick opens window number one
          wc_q    <= TIME_W'(1);
          start_q <= in_i.now_ms;
        end
      end

      if (ram_we) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end

      if ((state_q == S_CHK) && close_win) begin
        wc_q    <= wc_q + TIME_W'(1);
        start_q <= now_q;
        cnt_q   <= '0;
      end

      if ((state_q == S_LD) && ld_ok) begin
        ov_q <= 1'b1;
      end else if (out_fire) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      now_q    <= in_i.now_ms;
      sess_q   <= in_i.session_id;
      sig_q    <= in_i.signal;
      rate_q   <= in_i.resp_rate;
      srdy_q   <= in_i.sensor_ready;
      motion_q <= in_i.motion_level;
    end

    if (state_q == S_CALC) begin
      prod_q <= sig_q * $signed({1'b0, gain_q});
      dvd_q  <= now_q;
      rem_q  <= '0;
      it_q   <= '0;
    end

    if (state_q == S_DIV) begin
      dvd_q <= {dvd_q[TIME_W-2:0], 1'b0};
      rem_q <= rem_new;
      it_q  <= it_q + 5'd1;
    end

    if (state_q == S_CHK) begin
      hdr_wc_q    <= wc_q;
      hdr_start_q <= start_q;
      hdr_n_q     <= cnt_q;
      k_q         <= '0;
    end

    if ((state_q == S_LD) && ld_ok) begin
      o_sess_q   <= sess_q;
      o_wc_q     <= hdr_wc_q;
      o_start_q  <= hdr_start_q;
      o_end_q    <= now_q;
      o_rate_q   <= rate_q;
      o_qual_q   <= srdy_q ? qual_rdy_q : qual_nrdy_q;
      o_motion_q <= motion_q;
      o_n_q      <= hdr_n_q;
      o_pv_q     <= (hdr_n_q != '0);
      o_val_q    <= (hdr_n_q != '0) ? ram_rdata : '0;
      o_last_q   <= ld_last;
      k_q        <= k_q + CNT_W'(1);
    end
  end

  assign res_o.valid            = ov_q;
  assign res_o.session_out      = o_sess_q;
  assign res_o.window_number    = o_wc_q;
  assign res_o.window_start_ms  = o_start_q;
  assign res_o.window_end_ms    = o_end_q;
  assign res_o.rate_out         = o_rate_q;
  assign res_o.quality_out      = o_qual_q;
  assign res_o.motion_out       = o_motion_q;
  assign res_o.points_in_window = o_n_q;
  assign res_o.point_valid      = o_pv_q;
  assign res_o.point_value      = o_val_q;
  assign res_o.last_of_window   = o_last_q;

  // Point count never passes the store capacity
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CAP) else $error("point count above capacity");

  // A point is written only while there is room
  a_we_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (cnt_q < CAP)) else $error("point write into a full store");

  // An empty-window result is always the only and last one of its run
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.point_valid) |-> (res_o.last_of_window && res_o.points_in_window == '0))
    else $error("empty-window result malformed");

  // Loading the last result of a run returns the sequencer to idle
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_LD) && ld_ok && ld_last) |=> (state_q == S_IDLE))
    else $error("run did not end after last result");

  // The emit index stays inside the stored points
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> (k_q < hdr_n_q)) else $error("read past stored points");

endmodule

@@ dv/tb_sensor_sample_windower.sv @@
`timescale 1ns / 100ps

module tb_sensor_sample_windower;
  import ssw_pkg::*;

  // Worst item: scaling and remainder, then a memory read and a load per emitted point.
  localparam int unsigned DRAIN_CYCLES = 200;
  // Longest correct gap between two transactions is the drain above plus a stall.
  localparam int unsigned STALL_LIMIT  = 10000;

  // Indexes past the register list; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic              kind;
    logic [TIME_W-1:0] now;
    logic              en;
    logic [TIME_W-1:0] sess;
    logic [SIG_W-1:0]  sig;
    logic [BYTE_W-1:0] rate;
    logic              rdy;
    logic [BYTE_W-1:0] motion;
  } tick_t;

  typedef struct packed {
    logic [TIME_W-1:0]  session;
    logic [TIME_W-1:0]  wnum;
    logic [TIME_W-1:0]  wstart;
    logic [TIME_W-1:0]  wend;
    logic [BYTE_W-1:0]  rate;
    logic [BYTE_W-1:0]  qual;
    logic [BYTE_W-1:0]  motion;
    logic [CNT_W-1:0]   npts;
    logic               pvalid;
    logic [POINT_W-1:0] pval;
    logic               last;
  } window_res_t;

  // Directed row: when lit is set, the result below is typed in and replaces the prediction
  typedef struct packed {
    tick_t              t;
    logic               lit;
    logic               has_res;
    logic [TIME_W-1:0]  wnum;
    logic [TIME_W-1:0]  wstart;
    logic [BYTE_W-1:0]  qual;
    logic [CNT_W-1:0]   npts;
    logic [POINT_W-1:0] pval;
  } dir_row_t;

  // Reset configuration: period 200, length 10000, gain 5000, offset 32768, quality 88/30
  localparam dir_row_t DIRECTED [19] = '{
    // first enabled tick opens window 1 at t=0, point 32768
    '{'{KIND_TICK, 32'd0, 1'b1, 32'd1, 24'h00_0000, 8'd15, 1'b1, 8'd2},
      1'b1, 1'b0, 32'd0, 32'd0, 8'd0, 7'd0, 16'd0},
    // largest signal clamps to 65535
    '{'{KIND_TICK, 32'd200, 1'b1, 32'd2, 24'h7F_FFFF, 8'd16, 1'b1, 8'd3},
      1'b1, 1'b0, 32'd0, 32'd0, 8'd0, 7'd0, 16'd0},
    // off the sample grid, nothing stored
    '{'{KIND_TICK, 32'd300, 1'b1, 32'd3, 24'h12_3456, 8'd17, 1'b0, 8'd4},
      1'b1, 1'b0, 32'd0, 32'd0, 8'd0, 7'd0, 16'd0},
    // most negative signal clamps to 0
    '{'{KIND_TICK, 32'd400, 1'b1, 32'd4, 24'h80_0000, 8'd18, 1'b0, 8'd5},
      1'b1, 1'b0, 32'd0, 32'd0, 8'd0, 7'd0, 16'd0},
    // closes on the boundary with a point stored on the closing tick
    '{'{KIND_TICK, 32'd10000, 1'b1, 32'd5, 24'h01_0000, 8'd19, 1'b1, 8'd6},
      1'b0, 1'b0, 32'd0, 32'd0, 8'd0, 7'd0, 16'd0},
    // begin with all other fields at their top values
    '{'{KIND_BEGIN, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF, 8'hFF, 1'b1, 8'hFF},
      1'b1, 1'b0, 32'd0, 32'd0, 8'd0, 7'd0, 16'd0},
    // disabled tick
    '{'{KIND_TICK, 32'h7FFF_FFFF, 1'b0, 32'd6, 24'h7F_FFFF, 8'd20, 1'b1, 8'd7},
      1'b1, 1'b0, 32'd0, 32'd0, 8'd0, 7'd0, 16'd0},
    '{'{KIND_TICK, 32'd5, 1'b1, 32'd7, 24'h00_0100, 8'd21, 1'b1, 8'd8},
      1'b1, 1'b0, 32'd0, 32'd0, 8'd0, 7'd0, 16'd0},
    // one short of the window length
    '{'{KIND_TICK, 32'd10004, 1'b1, 32'd8, 24'h00_0200, 8'd22, 1'b1, 8'd9},
      1'b1, 1'b0, 32'd0, 32'd0, 8'd0, 7'd0, 16'd0},
    // empty window, sensor not ready
    '{'{KIND_TICK, 32'd10005, 1'b1, 32'hFFFF_FFFF, 24'h7F_FFFF, 8'hFF, 1'b0, 8'hFF},
      1'b1, 1'b1, 32'd1, 32'd5, 8'd30, 7'd0, 16'd0},
    // empty window, sensor ready, zero header fields
    '{'{KIND_TICK, 32'd20005, 1'b1, 32'd0, 24'h80_0000, 8'd0, 1'b1, 8'd0},
      1'b1, 1'b1, 32'd2, 32'd10005, 8'd88, 7'd0, 16'd0},
    '{'{KIND_TICK, 32'd20100, 1'b0, 32'd9, 24'h00_0000, 8'd23, 1'b1, 8'd10},
      1'b1, 1'b0, 32'd0, 32'd0, 8'd0, 7'd0, 16'd0},
    '{'{KIND_TICK, 32'd30000, 1'b1, 32'd10, 24'h00_0000, 8'd24, 1'b1, 8'd11},
      1'b1, 1'b0, 32'd0, 32'd0, 8'd0, 7'd0, 16'd0},
    // single point window, restarted by the disabled tick
    '{'{KIND_TICK, 32'd30100, 1'b1, 32'd11, 24'hAB_CDEF, 8'd25, 1'b1, 8'd12},
      1'b1, 1'b1, 32'd3, 32'd20100, 8'd88, 7'd1, 16'd32768},
    // window straddling the 32-bit time wrap
    '{'{KIND_BEGIN, 32'hFFFF_F000, 1'b0, 32'd0, 24'h00_0000, 8'd0, 1'b0, 8'd0},
      1'b1, 1'b0, 32'd0, 32'd0, 8'd0, 7'd0, 16'd0},
    '{'{KIND_TICK, 32'hFFFF_FFF0, 1'b1, 32'd12, 24'hFF_0000, 8'd26, 1'b1, 8'd13},
      1'b0, 1'b0, 32'd0, 32'd0, 8'd0, 7'd0, 16'd0},
    '{'{KIND_TICK, 32'd0, 1'b1, 32'd13, 24'hFF_FFFF, 8'd27, 1'b0, 8'd14},
      1'b0, 1'b0, 32'd0, 32'd0, 8'd0, 7'd0, 16'd0},
    '{'{KIND_TICK, 32'h0000_2000, 1'b1, 32'd14, 24'h00_8000, 8'd28, 1'b1, 8'd15},
      1'b0, 1'b0, 32'd0, 32'd0, 8'd0, 7'd0, 16'd0},
    '{'{KIND_TICK, 32'd10000, 1'b1, 32'd15, 24'hC0_0000, 8'd29, 1'b0, 8'd16},
      1'b0, 1'b0, 32'd0, 32'd0, 8'd0, 7'd0, 16'd0}
  };

  logic clk_i;
  logic rst_ni;

  ssw_cfg_if cfg_if ();
  ssw_in_if  in_if ();
  ssw_out_if res_if ();

  sensor_sample_windower dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .res_o  (res_if)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Shadow registers and window state
  logic [PERIOD_W-1:0] per_r  = SAMPLE_PERIOD_RST;
  logic [TIME_W-1:0]   len_r  = WINDOW_LENGTH_RST;
  logic [GAIN_W-1:0]   gain_r = SIGNAL_GAIN_RST;
  logic [GAIN_W-1:0]   offs_r = SIGNAL_OFFSET_RST;
  logic [BYTE_W-1:0]   qr_r   = QUAL_READY_RST;
  logic [BYTE_W-1:0]   qn_r   = QUAL_NREADY_RST;

  logic [TIME_W-1:0]   win_num   = '0;
  logic [TIME_W-1:0]   win_start = '0;
  int unsigned         pt_cnt    = 0;
  logic [POINT_W-1:0]  pt_mem [POINT_CAPACITY_DEF];

  window_res_t due_results [$];
  logic [TIME_W-1:0] cur_now = '0;
  int unsigned src_gap_pct   = 6;
  int unsigned snk_stall_pct = 85;
  int unsigned err_cnt       = 0;
  int unsigned stall_cycles  = 0;

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_SAMPLE_PERIOD: per_r  = data[PERIOD_W-1:0];
      REG_WINDOW_LENGTH: len_r  = data[TIME_W-1:0];
      REG_SIGNAL_GAIN:   gain_r = data[GAIN_W-1:0];
      REG_SIGNAL_OFFSET: offs_r = data[GAIN_W-1:0];
      REG_QUAL_READY:    qr_r   = data[BYTE_W-1:0];
      REG_QUAL_NREADY:   qn_r   = data[BYTE_W-1:0];
      default: ;
    endcase
  endfunction

  // signal * gain + offset * 2^16, floored to the integer part and clamped
  function automatic logic [POINT_W-1:0] scale_sample(input logic [SIG_W-1:0] raw);
    longint acc;
    acc = longint'($signed(raw)) * longint'(gain_r) + (longint'(offs_r) << 16);
    if (acc < 0) return '0;
    if ((acc >>> 16) > 65535) return 16'hFFFF;
    return 16'(acc >>> 16);
  endfunction

  // Advances the window state by one tick; queues the results it closes, returns how many
  function automatic int unsigned predict_window(input tick_t t);
    window_res_t r;
    logic [TIME_W-1:0] elapsed;
    int unsigned nres;
    int unsigned k;
    if (t.kind == KIND_BEGIN) begin
      win_num = '0;
      win_start = t.now;
      pt_cnt = 0;
      return 0;
    end
    if (!t.en) begin
      pt_cnt = 0;
      win_start = t.now;
      return 0;
    end
    if (win_num == '0) begin
      win_num = 32'd1;
      win_start = t.now;
    end
    if (pt_cnt < POINT_CAPACITY_DEF && per_r != '0 && (t.now % per_r) == '0) begin
      pt_mem[pt_cnt] = scale_sample(t.sig);
      pt_cnt++;
    end
    elapsed = t.now - win_start;
    if (elapsed < len_r) return 0;
    nres = (pt_cnt == 0) ? 1 : pt_cnt;
    for (k = 0; k < nres; k++) begin
      r.session = t.sess;
      r.wnum    = win_num;
      r.wstart  = win_start;
      r.wend    = t.now;
      r.rate    = t.rate;
      r.qual    = t.rdy ? qr_r : qn_r;
      r.motion  = t.motion;
      r.npts    = CNT_W'(pt_cnt);
      r.pvalid  = (pt_cnt != 0);
      r.pval    = (pt_cnt != 0) ? pt_mem[k] : '0;
      r.last    = (k + 1 == nres);
      due_results.push_back(r);
    end
    win_num   = win_num + 32'd1;
    win_start = t.now;
    pt_cnt    = 0;
    return nres;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  // Result side: compare each accepted transaction with the oldest prediction
  always @(posedge clk_i) begin
    window_res_t w;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (due_results.size() == 0) begin
        $error("result transaction with nothing predicted (window_number 0x%0h)",
               res_if.window_number);
        err_cnt++;
      end else begin
        w = due_results.pop_front();
        check_field("session_out", w.session, res_if.session_out);
        check_field("window_number", w.wnum, res_if.window_number);
        check_field("window_start_ms", w.wstart, res_if.window_start_ms);
        check_field("window_end_ms", w.wend, res_if.window_end_ms);
        check_field("rate_out", w.rate, res_if.rate_out);
        check_field("quality_out", w.qual, res_if.quality_out);
        check_field("motion_out", w.motion, res_if.motion_out);
        check_field("points_in_window", w.npts, res_if.points_in_window);
        check_field("point_valid", w.pvalid, res_if.point_valid);
        check_field("point_value", w.pval, res_if.point_value);
        check_field("last_of_window", w.last, res_if.last_of_window);
      end
    end
  end

  // Receiver back-pressure
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // Watchdog: cycles since the last transaction on any channel
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  // Offers one tick transaction, with random gaps before it, and predicts at acceptance
  task automatic drive_tick(input tick_t t, output int unsigned n_res);
    while ($urandom_range(0, 99) < src_gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.kind         <= t.kind;
    in_if.now_ms       <= t.now;
    in_if.enabled      <= t.en;
    in_if.session_id   <= t.sess;
    in_if.signal       <= t.sig;
    in_if.resp_rate    <= t.rate;
    in_if.sensor_ready <= t.rdy;
    in_if.motion_level <= t.motion;
    do @(posedge clk_i); while (!in_if.ready);
    cur_now = t.now;
    n_res = predict_window(t);
  endtask

  // Waits for every predicted result, then lets the block finish work that yields none
  task automatic wait_idle();
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    apply_reg(idx, data);
  endtask

  // Unused upper bits of wdata carry noise, the block must drop them
  task automatic set_config(input logic [PERIOD_W-1:0] per, input logic [TIME_W-1:0] len,
                            input logic [GAIN_W-1:0] gain, input logic [GAIN_W-1:0] offs,
                            input logic [BYTE_W-1:0] qr, input logic [BYTE_W-1:0] qn);
    wait_idle();
    cfg_write(REG_SAMPLE_PERIOD, {16'($urandom()), per});
    cfg_write(REG_WINDOW_LENGTH, len);
    cfg_write(REG_SIGNAL_GAIN, {16'($urandom()), gain});
    cfg_write(REG_SIGNAL_OFFSET, {16'($urandom()), offs});
    cfg_write(REG_QUAL_READY, {24'($urandom()), qr});
    cfg_write(REG_QUAL_NREADY, {24'($urandom()), qn});
    cfg_write($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom());
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly a time line moving forward, landing on the sample grid and on the window
  // boundary; jump_pct aims ticks at or just short of the close, noise_pct gives
  // begins and disabled ticks.
  task automatic run_stream(input int unsigned n_items, input int unsigned jump_pct,
                            input int unsigned noise_pct);
    tick_t t;
    logic [TIME_W-1:0] nxt;
    int unsigned roll;
    int unsigned n_res;
    repeat (n_items) begin
      t.kind   = KIND_TICK;
      t.en     = 1'b1;
      t.sess   = $urandom();
      t.sig    = 24'($urandom());
      t.rate   = 8'($urandom());
      t.rdy    = 1'($urandom());
      t.motion = 8'($urandom());
      roll = $urandom_range(0, 99);
      if (roll < jump_pct / 2)
        nxt = win_start + len_r;
      else if (roll < jump_pct)
        nxt = win_start + len_r - 32'd1;
      else if (roll < jump_pct + 2)
        nxt = $urandom();
      else if (roll < 55 || per_r == '0)
        nxt = cur_now + $urandom_range(1, 2);
      else
        nxt = cur_now + (per_r - cur_now % per_r);
      roll = $urandom_range(0, 99);
      if (roll < noise_pct) begin
        t.kind = KIND_BEGIN;
        t.en   = 1'($urandom());
        if ($urandom_range(0, 1)) nxt = $urandom();
      end else if (roll < 2 * noise_pct) begin
        t.en = 1'b0;
      end
      t.now = nxt;
      drive_tick(t, n_res);
    end
    in_if.valid <= 1'b0;
  endtask

  initial begin
    window_res_t fixed_r;
    int unsigned n_res;

    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.kind         <= KIND_TICK;
    in_if.now_ms       <= '0;
    in_if.enabled      <= 1'b0;
    in_if.session_id   <= '0;
    in_if.signal       <= '0;
    in_if.resp_rate    <= '0;
    in_if.sensor_ready <= 1'b0;
    in_if.motion_level <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= REG_SAMPLE_PERIOD;
    cfg_if.wdata       <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on the reset configuration
    for (int i = 0; i < $size(DIRECTED); i++) begin
      drive_tick(DIRECTED[i].t, n_res);
      if (DIRECTED[i].lit) begin
        repeat (n_res) void'(due_results.pop_back());
        if (DIRECTED[i].has_res) begin
          fixed_r.session = DIRECTED[i].t.sess;
          fixed_r.wnum    = DIRECTED[i].wnum;
          fixed_r.wstart  = DIRECTED[i].wstart;
          fixed_r.wend    = DIRECTED[i].t.now;
          fixed_r.rate    = DIRECTED[i].t.rate;
          fixed_r.qual    = DIRECTED[i].qual;
          fixed_r.motion  = DIRECTED[i].t.motion;
          fixed_r.npts    = DIRECTED[i].npts;
          fixed_r.pvalid  = (DIRECTED[i].npts != '0);
          fixed_r.pval    = DIRECTED[i].pval;
          fixed_r.last    = 1'b1;
          due_results.push_back(fixed_r);
        end
      end
    end
    in_if.valid <= 1'b0;

    // Every tick samples and windows run past 64 ticks: full store, extreme gain
    set_config(16'd1, 32'd100, 16'hFFFF, 16'h0000, 8'hFF, 8'h00);
    run_stream(130, 0, 1);

    // Zero period and zero length: every enabled tick closes an empty window
    set_config(16'd0, 32'd0, 16'h0000, 16'hFFFF, 8'h00, 8'hFF);
    run_stream(30, 10, 5);

    src_gap_pct   = 85;
    snk_stall_pct = 6;
    // Largest period and length: closes only one millisecond before the start time
    set_config(16'hFFFF, 32'hFFFF_FFFF, 16'($urandom()), 16'($urandom()),
               8'($urandom()), 8'($urandom()));
    run_stream(40, 20, 3);

    for (int p = 0; p < 3; p++) begin
      if (p == 1) begin
        src_gap_pct   = 0;
        snk_stall_pct = 0;
      end
      set_config(16'($urandom_range(1, 8)), 32'($urandom_range(1, 150)),
                 16'($urandom()), 16'($urandom()), 8'($urandom()), 8'($urandom()));
      run_stream(50, 8, 3);
    end

    wait_idle();
    if (err_cnt == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
